// ===== src/aabf_pkg.sv =====
// ----------------------------------------------------------------------------
// aabf_pkg: shared definitions of the auto-brightness fader
// Default widths, configuration register indexes, reset values, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aabf_pkg;

	localparam int SENSOR_BITS_DEF = 12;
	localparam int LEVEL_BITS_DEF  = 8;
	localparam int ELAPSED_BITS    = 16;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_FLOOR      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_CEIL       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_STEP_SIZE   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_STEP_DELAY  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_AMBIENT_INTERVAL = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_MIN       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SENSOR_MAX       = 3'd6;

	// reset values, truncated to the configured widths where they are used
	localparam int LEVEL_FLOOR_RESET      = 0;
	localparam int LEVEL_CEIL_RESET       = 255;
	localparam int FADE_STEP_SIZE_RESET   = 1;
	localparam int FADE_STEP_DELAY_RESET  = 10;
	localparam int AMBIENT_INTERVAL_RESET = 1000;
	localparam int SENSOR_MIN_RESET       = 0;
	localparam int SENSOR_MAX_RESET       = 4095;

	// input op codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_FORCE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FORCE,
		ST_TICK,
		ST_MUL,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;    // latch the incoming item
		logic force_lvl; // apply a forced level
		logic tick;      // advance counters, fade, ambient decision
		logic mul;       // form the scaled numerator
		logic div;       // one restoring divide step
		logic wb;        // write the mapped goal level
		logic load_out;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic map_start; // ambient sampling needs the linear map
	} status_t;

endpackage

// ===== src/aabf_if.sv =====
// ----------------------------------------------------------------------------
// aabf_if: item channels of the auto-brightness fader
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface aabf_in_if #(
	parameter int SENSOR_BITS = aabf_pkg::SENSOR_BITS_DEF,
	parameter int LEVEL_BITS  = aabf_pkg::LEVEL_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [SENSOR_BITS-1:0] light_sample;
	logic [LEVEL_BITS-1:0]  forced_level;

	modport source (output valid, output op, output light_sample, output forced_level,
		input ready);
	modport sink (input valid, input op, input light_sample, input forced_level,
		output ready);
endinterface

interface aabf_out_if #(
	parameter int LEVEL_BITS = aabf_pkg::LEVEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] duty_level;
	logic [LEVEL_BITS-1:0] target_level;

	modport source (output valid, output duty_level, output target_level, input ready);
	modport sink (input valid, input duty_level, input target_level, output ready);
endinterface

// ===== src/ambient_auto_brightness_fader_core.sv =====
// ----------------------------------------------------------------------------
// ambient_auto_brightness_fader_core: ambient-light auto-brightness fader
// Input items are either a one-millisecond tick with a photosensor sample
// (op clear) or a forced brightness level (op set). Each item yields one
// result item carrying the duty level and the target level after it.
// Configuration goes through a plain write port (cfg_we, cfg_index,
// cfg_wdata); write it only while no item is in flight.
// A force goes through the force state and a tick with no linear map through
// the tick state to the done state, which loads the result register and
// raises out_ch.valid once the output is free; a tick whose sampling needs
// the linear map also takes a multiply step, one restoring-divide step per
// quotient bit and a write-back before done. The divider sets the worst case.
// One item is worked on at a time; in_ch.ready is high only when idle.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits; a stalled receiver holds that result and only
// blocks the following item at the point of loading its own result.
// Reset clears out_ch.valid, loads the register defaults and sets duty and
// target level to the level ceiling default with both elapsed counters at 0.
// ----------------------------------------------------------------------------
module ambient_auto_brightness_fader_core #(
	parameter int SENSOR_BITS = aabf_pkg::SENSOR_BITS_DEF,
	parameter int LEVEL_BITS  = aabf_pkg::LEVEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	aabf_in_if.sink                            in_ch,
	aabf_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [aabf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [aabf_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	aabf_pkg::cmd_t    cmd;
	aabf_pkg::status_t status;

	// sequencing: accept, step through the map, hand the result over
	aabf_ctrl #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd),
		.status    (status)
	);

	// registers, level state, fade and linear map arithmetic
	aabf_dp #(
		.SENSOR_BITS (SENSOR_BITS),
		.LEVEL_BITS  (LEVEL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_op        (in_ch.op),
		.in_sample    (in_ch.light_sample),
		.in_forced    (in_ch.forced_level),
		.cmd          (cmd),
		.status       (status),
		.duty_level   (out_ch.duty_level),
		.target_level (out_ch.target_level)
	);

endmodule

// ===== src/aabf_ctrl.sv =====
// ----------------------------------------------------------------------------
// aabf_ctrl: sequencing controller
// Walks one item through force, tick, multiply, divide and write-back, and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module aabf_ctrl #(
	parameter int LEVEL_BITS = aabf_pkg::LEVEL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output aabf_pkg::cmd_t    cmd,
	input  aabf_pkg::status_t status
);

	localparam int CNT_BITS = $clog2(LEVEL_BITS);

	aabf_pkg::state_t      state_q, state_d;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  out_valid_q;
	logic                  div_last;
	logic                  out_free;

	assign div_last = (cnt_q == CNT_BITS'(LEVEL_BITS - 1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			aabf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_op == aabf_pkg::OP_FORCE) ? aabf_pkg::ST_FORCE
						: aabf_pkg::ST_TICK;
				end
			end
			aabf_pkg::ST_FORCE: state_d = aabf_pkg::ST_DONE;
			aabf_pkg::ST_TICK: begin
				state_d = status.map_start ? aabf_pkg::ST_MUL : aabf_pkg::ST_DONE;
			end
			aabf_pkg::ST_MUL: state_d = aabf_pkg::ST_DIV;
			aabf_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = aabf_pkg::ST_WB;
				end
			end
			aabf_pkg::ST_WB: state_d = aabf_pkg::ST_DONE;
			aabf_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = aabf_pkg::ST_IDLE;
				end
			end
			default: state_d = aabf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			aabf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			aabf_pkg::ST_FORCE: cmd.force_lvl = 1'b1;
			aabf_pkg::ST_TICK:  cmd.tick = 1'b1;
			aabf_pkg::ST_MUL:   cmd.mul = 1'b1;
			aabf_pkg::ST_DIV:   cmd.div = 1'b1;
			aabf_pkg::ST_WB:    cmd.wb = 1'b1;
			aabf_pkg::ST_DONE:  cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aabf_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/aabf_dp.sv =====
// ----------------------------------------------------------------------------
// aabf_dp: fader datapath
// Configuration registers, level and elapsed-time state, the fade step, the
// sensor clamp, one multiplier and a restoring divider, and the result register.
// ----------------------------------------------------------------------------
module aabf_dp #(
	parameter int SENSOR_BITS = aabf_pkg::SENSOR_BITS_DEF,
	parameter int LEVEL_BITS  = aabf_pkg::LEVEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aabf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [aabf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                in_op,
	input  logic [SENSOR_BITS-1:0]              in_sample,
	input  logic [LEVEL_BITS-1:0]               in_forced,
	input  aabf_pkg::cmd_t                      cmd,
	output aabf_pkg::status_t                   status,
	output logic [LEVEL_BITS-1:0]               duty_level,
	output logic [LEVEL_BITS-1:0]               target_level
);

	localparam int S  = SENSOR_BITS;
	localparam int L  = LEVEL_BITS;
	localparam int EB = aabf_pkg::ELAPSED_BITS;

	// configuration
	logic [L-1:0]  bmin_q, bmax_q, step_size_q;
	logic [EB-1:0] delay_q, interval_q;
	logic [S-1:0]  smin_q, smax_q;

	// state
	logic [L-1:0]  cur_q, goal_q;
	logic [EB-1:0] fade_cnt_q, amb_cnt_q;

	// latched item
	logic          op_q;
	logic [S-1:0]  sample_q;
	logic [L-1:0]  forced_q;

	// linear map
	logic [S-1:0]  d_q, den_q, rem_q;
	logic [L-1:0]  mag_q, lo_q;
	logic          neg_q;

	// result register
	logic [L-1:0]  duty_q, target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmin_q      <= L'(aabf_pkg::LEVEL_FLOOR_RESET);
			bmax_q      <= L'(aabf_pkg::LEVEL_CEIL_RESET);
			step_size_q <= L'(aabf_pkg::FADE_STEP_SIZE_RESET);
			delay_q     <= EB'(aabf_pkg::FADE_STEP_DELAY_RESET);
			interval_q  <= EB'(aabf_pkg::AMBIENT_INTERVAL_RESET);
			smin_q      <= S'(aabf_pkg::SENSOR_MIN_RESET);
			smax_q      <= S'(aabf_pkg::SENSOR_MAX_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				aabf_pkg::CFG_LEVEL_FLOOR:      bmin_q      <= cfg_wdata[L-1:0];
				aabf_pkg::CFG_LEVEL_CEIL:       bmax_q      <= cfg_wdata[L-1:0];
				aabf_pkg::CFG_FADE_STEP_SIZE:   step_size_q <= cfg_wdata[L-1:0];
				aabf_pkg::CFG_FADE_STEP_DELAY:  delay_q     <= cfg_wdata[EB-1:0];
				aabf_pkg::CFG_AMBIENT_INTERVAL: interval_q  <= cfg_wdata[EB-1:0];
				aabf_pkg::CFG_SENSOR_MIN:       smin_q      <= cfg_wdata[S-1:0];
				aabf_pkg::CFG_SENSOR_MAX:       smax_q      <= cfg_wdata[S-1:0];
				default: ;
			endcase
		end
	end

	// force clamp
	logic [L-1:0] forced_clamped;
	assign forced_clamped = (forced_q < bmin_q) ? bmin_q
		: ((forced_q > bmax_q) ? bmax_q : forced_q);

	// saturating elapsed counters
	logic [EB-1:0] fade_inc, amb_inc;
	assign fade_inc = (fade_cnt_q == '1) ? fade_cnt_q : fade_cnt_q + EB'(1);
	assign amb_inc  = (amb_cnt_q == '1) ? amb_cnt_q : amb_cnt_q + EB'(1);

	// fade step
	logic         fade_fire, going_up;
	logic [L-1:0] distance, fade_amt, cur_faded;
	assign going_up  = goal_q > cur_q;
	assign distance  = going_up ? goal_q - cur_q : cur_q - goal_q;
	assign fade_amt  = (step_size_q < distance) ? step_size_q : distance;
	assign cur_faded = going_up ? cur_q + fade_amt : cur_q - fade_amt;
	assign fade_fire = (cur_q != goal_q) && (fade_inc >= delay_q);

	// ambient sampling
	logic         amb_fire, bounds_equal, bounds_swapped;
	logic [S-1:0] x_clamped;
	assign amb_fire       = amb_inc >= interval_q;
	assign bounds_equal   = smin_q == smax_q;
	assign bounds_swapped = smin_q > smax_q;
	assign x_clamped = (sample_q < smin_q) ? smin_q
		: ((sample_q > smax_q) ? smax_q : sample_q);

	assign status.map_start = cmd.tick && (op_q == aabf_pkg::OP_TICK) && amb_fire
		&& !bounds_equal && !bounds_swapped;

	// numerator and restoring divide step
	logic [S+L-1:0] prod;
	logic [S:0]     trial, trial_diff;
	logic           q_bit;
	assign prod       = (S+L)'(d_q) * (S+L)'(mag_q);
	assign trial      = {rem_q, lo_q[L-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign q_bit      = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= in_op;
			sample_q <= in_sample;
			forced_q <= in_forced;
		end
		if (cmd.tick) begin
			d_q   <= x_clamped - smin_q;
			den_q <= smax_q - smin_q;
			neg_q <= bmax_q < bmin_q;
			mag_q <= (bmax_q < bmin_q) ? bmin_q - bmax_q : bmax_q - bmin_q;
		end
		if (cmd.mul) begin
			rem_q <= prod[S+L-1:L];
			lo_q  <= prod[L-1:0];
		end else if (cmd.div) begin
			rem_q <= q_bit ? trial_diff[S-1:0] : trial[S-1:0];
			lo_q  <= {lo_q[L-2:0], q_bit};
		end
		if (cmd.load_out) begin
			duty_q   <= cur_q;
			target_q <= goal_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= L'(aabf_pkg::LEVEL_CEIL_RESET);
			goal_q     <= L'(aabf_pkg::LEVEL_CEIL_RESET);
			fade_cnt_q <= '0;
			amb_cnt_q  <= '0;
		end else begin
			if (cmd.force_lvl) begin
				cur_q  <= forced_clamped;
				goal_q <= forced_clamped;
			end else if (cmd.tick) begin
				fade_cnt_q <= fade_fire ? '0 : fade_inc;
				amb_cnt_q  <= amb_fire ? '0 : amb_inc;
				if (fade_fire) begin
					cur_q <= cur_faded;
				end
				if (amb_fire && bounds_equal) begin
					goal_q <= bmin_q;
				end else if (amb_fire && bounds_swapped) begin
					goal_q <= (sample_q < smin_q) ? bmin_q : bmax_q;
				end
			end else if (cmd.wb) begin
				goal_q <= neg_q ? bmin_q - lo_q : bmin_q + lo_q;
			end
		end
	end

	assign duty_level   = duty_q;
	assign target_level = target_q;

endmodule

// ===== test/ambient_auto_brightness_fader_core_tb.sv =====
// ----------------------------------------------------------------------------
// ambient_auto_brightness_fader_core_tb: self-checking bench of the fader core
// Sends ticks with light samples and forced levels through the input channel
// under random pacing on both sides. A local model of the fader predicts the
// duty and target level of every item, and each result item is compared
// field by field with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module ambient_auto_brightness_fader_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB          = aabf_pkg::SENSOR_BITS_DEF;
	localparam int LB          = aabf_pkg::LEVEL_BITS_DEF;
	localparam int IB          = aabf_pkg::CFG_IDX_BITS;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 50;
	localparam logic [15:0] COUNT_CEIL = 16'hFFFF;
	// index 7 decodes to no register, so a write there must change nothing
	localparam logic [IB-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic          op;
		logic [SB-1:0] sample;
		logic [LB-1:0] level;
	} fader_item_t;

	typedef struct {
		logic [LB-1:0] duty;
		logic [LB-1:0] target;
	} levels_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [IB-1:0]                      cfg_index;
	logic [aabf_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

	aabf_in_if #(.SENSOR_BITS(SB), .LEVEL_BITS(LB)) in_ch ();
	aabf_out_if #(.LEVEL_BITS(LB)) out_ch ();

	ambient_auto_brightness_fader_core #(
		.SENSOR_BITS(SB),
		.LEVEL_BITS (LB)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Local copy of the configuration
	logic [LB-1:0] lvl_floor;
	logic [LB-1:0] lvl_ceil;
	logic [LB-1:0] step_max;
	logic [15:0]   step_delay;
	logic [15:0]   sample_period;
	logic [SB-1:0] sens_lo;
	logic [SB-1:0] sens_hi;

	// Local copy of the fader state
	logic [LB-1:0] duty_now;
	logic [LB-1:0] goal_now;
	logic [15:0]   fade_count;
	logic [15:0]   ambient_count;

	levels_t levels_due[$];     // predicted levels, oldest first
	int      mismatches = 0;
	int      cycles     = 0;
	bit      pacing_on  = 1'b1; // random gaps on both channels when set

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Lower bound wins first, then the upper one: this also fixes the result
	// when the bounds are given the wrong way round.
	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void reset_fader_model();
		lvl_floor     = LB'(aabf_pkg::LEVEL_FLOOR_RESET);
		lvl_ceil      = LB'(aabf_pkg::LEVEL_CEIL_RESET);
		step_max      = LB'(aabf_pkg::FADE_STEP_SIZE_RESET);
		step_delay    = 16'(aabf_pkg::FADE_STEP_DELAY_RESET);
		sample_period = 16'(aabf_pkg::AMBIENT_INTERVAL_RESET);
		sens_lo       = SB'(aabf_pkg::SENSOR_MIN_RESET);
		sens_hi       = SB'(aabf_pkg::SENSOR_MAX_RESET);
		duty_now      = lvl_ceil;
		goal_now      = lvl_ceil;
		fade_count    = '0;
		ambient_count = '0;
	endfunction

	function automatic void apply_reg(logic [IB-1:0] idx, logic [15:0] v);
		case (idx)
			aabf_pkg::CFG_LEVEL_FLOOR:      lvl_floor = v[LB-1:0];
			aabf_pkg::CFG_LEVEL_CEIL:       lvl_ceil = v[LB-1:0];
			aabf_pkg::CFG_FADE_STEP_SIZE:   step_max = v[LB-1:0];
			aabf_pkg::CFG_FADE_STEP_DELAY:  step_delay = v;
			aabf_pkg::CFG_AMBIENT_INTERVAL: sample_period = v;
			aabf_pkg::CFG_SENSOR_MIN:       sens_lo = v[SB-1:0];
			aabf_pkg::CFG_SENSOR_MAX:       sens_hi = v[SB-1:0];
			default: ;
		endcase
	endfunction

	// Advance the model by one accepted item and return the levels it leaves.
	function automatic levels_t next_levels(fader_item_t it);
		longint        x;
		longint        lo_s;
		longint        hi_s;
		longint        fl_s;
		longint        ce_s;
		longint        span;
		longint        den;
		longint        scaled;
		logic [LB-1:0] apart;
		logic [LB-1:0] step;
		levels_t       r;

		if (it.op == aabf_pkg::OP_FORCE) begin
			duty_now = LB'(clamp_int(int'(it.level), int'(lvl_floor), int'(lvl_ceil)));
			goal_now = duty_now;
		end else begin
			// both counters saturate rather than wrap
			if (fade_count != COUNT_CEIL)
				fade_count++;
			if (ambient_count != COUNT_CEIL)
				ambient_count++;

			// fade: only when apart and the delay has run out; a zero step
			// still restarts the delay
			if (duty_now != goal_now && fade_count >= step_delay) begin
				apart = (goal_now > duty_now) ? goal_now - duty_now : duty_now - goal_now;
				step = (step_max < apart) ? step_max : apart;
				duty_now = (goal_now > duty_now) ? duty_now + step : duty_now - step;
				fade_count = '0;
			end

			// sampling: clamp, then scale with truncation toward zero
			if (ambient_count >= sample_period) begin
				ambient_count = '0;
				if (sens_lo == sens_hi) begin
					goal_now = lvl_floor;
				end else begin
					lo_s   = longint'(sens_lo);
					hi_s   = longint'(sens_hi);
					fl_s   = longint'(lvl_floor);
					ce_s   = longint'(lvl_ceil);
					x      = longint'(clamp_int(int'(it.sample), int'(sens_lo),
						int'(sens_hi)));
					span   = (x - lo_s) * (ce_s - fl_s);
					den    = hi_s - lo_s;
					scaled = span / den + fl_s;
					goal_now = scaled[LB-1:0];
				end
			end
		end

		r.duty   = duty_now;
		r.target = goal_now;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Sample the result channel at the edge itself, so the values seen are
	// those the handshake moved.
	always @(posedge clk) begin
		levels_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (levels_due.size() == 0) begin
				report($sformatf("result item with nothing pending (duty %0d target %0d)",
					out_ch.duty_level, out_ch.target_level));
			end else begin
				want = levels_due.pop_front();
				if (out_ch.duty_level !== want.duty)
					report($sformatf("duty_level %0d, predicted %0d",
						out_ch.duty_level, want.duty));
				if (out_ch.target_level !== want.target)
					report($sformatf("target_level %0d, predicted %0d",
						out_ch.target_level, want.target));
			end
		end
	end

	// Result receiver: draw a stall per item; with no stall keep ready high
	// so that ready is never dropped and raised in the same step.
	initial begin : result_sink
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pacing_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// Watchdog
	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("** ambient_auto_brightness_fader_core: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------------

	// Drop valid and hold until every prediction is met and the core is
	// back in its idle state.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (levels_due.size() != 0 || !in_ch.ready);
	endtask

	// One register write per edge; the caller lowers the write enable.
	task automatic write_reg(logic [IB-1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[aabf_pkg::CFG_DATA_BITS-1:0];
		apply_reg(idx, value[15:0]);
		@(posedge clk);
	endtask

	// Reprogram the whole register set once the core is idle. Each pass
	// starts with a stray write to the unused index, which must be ignored.
	task automatic program_fader(int fl, int ce, int step, int delay, int period,
		int lo, int hi);
		wait_idle();
		write_reg(CFG_UNUSED, int'($urandom_range(0, 65535)));
		write_reg(aabf_pkg::CFG_LEVEL_FLOOR, fl);
		write_reg(aabf_pkg::CFG_LEVEL_CEIL, ce);
		write_reg(aabf_pkg::CFG_FADE_STEP_SIZE, step);
		write_reg(aabf_pkg::CFG_FADE_STEP_DELAY, delay);
		write_reg(aabf_pkg::CFG_AMBIENT_INTERVAL, period);
		write_reg(aabf_pkg::CFG_SENSOR_MIN, lo);
		write_reg(aabf_pkg::CFG_SENSOR_MAX, hi);
		cfg_we <= 1'b0;
	endtask

	// Send one item and record its prediction on acceptance. Valid is left
	// high after the handshake so that back-to-back items need no toggle.
	task automatic send_item(logic op, int sample, int level);
		fader_item_t it;
		int          gap;
		it.op     = op;
		it.sample = sample[SB-1:0];
		it.level  = level[LB-1:0];
		gap = pacing_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.op           <= it.op;
		in_ch.light_sample <= it.sample;
		in_ch.forced_level <= it.level;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		levels_due.push_back(next_levels(it));
	endtask

	// Unused fields carry random noise: the core must ignore them.
	task automatic send_tick(int sample);
		send_item(aabf_pkg::OP_TICK, sample, int'($urandom_range(0, 255)));
	endtask

	task automatic send_force(int level);
		send_item(aabf_pkg::OP_FORCE, int'($urandom_range(0, 4095)), level);
	endtask

	// ------------------------------------------------------------------------
	// Random picks
	// ------------------------------------------------------------------------

	function automatic int pick_level();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int pick_sensor();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// Mostly short timers so that fades and samplings happen often
	function automatic int pick_timer();
		case ($urandom_range(0, 9))
			0, 1:    return 0;
			7, 8:    return $urandom_range(7, 40);
			9:       return $urandom_range(0, 1) ? 65535 : $urandom_range(41, 65535);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic int pick_step();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 255;
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Defaults: 10 ms fade delay and 1 s sampling, so a couple of ticks
	// leave both levels at full brightness; forces hit both extremes.
	task automatic test_reset_state();
		send_tick(0);
		send_tick(4095);
		send_force(0);
		send_force(255);
		send_tick(2048);
	endtask

	// Forced levels outside the brightness window are clamped into it.
	task automatic test_force_clamp();
		program_fader(40, 200, 1, 10, 1000, 0, 4095);
		send_force(0);
		send_force(255);
		send_force(100);
	endtask

	// Sample on every tick with a full-range step: below, above and inside
	// the sensor window.
	task automatic test_map_extremes();
		program_fader(0, 255, 255, 0, 0, 100, 3000);
		send_tick(0);
		send_tick(4095);
		send_tick(1550);
	endtask

	// A zero-width sensor window sends the goal to the brightness floor.
	task automatic test_equal_sensor_bounds();
		program_fader(30, 220, 255, 0, 0, 2000, 2000);
		send_tick(4095);
		send_tick(0);
	endtask

	// Both windows given upside down: clamps and map must stay in range.
	task automatic test_inverted_bounds();
		program_fader(200, 50, 255, 0, 0, 3000, 1000);
		send_tick(0);
		send_tick(4095);
		send_tick(2000);
		send_force(100);
	endtask

	// A zero step fires the fade but leaves the level where it is.
	task automatic test_zero_step();
		program_fader(0, 255, 0, 2, 0, 0, 4095);
		send_force(10);
		repeat (3) send_tick(4095);
	endtask

	// Slew-limited fade with a delay between steps.
	task automatic test_slow_fade();
		program_fader(0, 255, 7, 3, 2, 0, 4095);
		send_force(255);
		repeat (4) send_tick(0);
	endtask

	// Random register settings per phase, random items within each phase.
	task automatic test_random_phases();
		int fl;
		int ce;
		int lo;
		int hi;
		int t;
		for (int p = 0; p < PHASES; p++) begin
			// leave one phase in four without any gaps
			pacing_on = ($urandom_range(0, 3) != 0);

			fl = pick_level();
			ce = pick_level();
			if ($urandom_range(0, 4) != 0 && fl > ce) begin
				t  = fl;
				fl = ce;
				ce = t;
			end
			lo = pick_sensor();
			hi = pick_sensor();
			case ($urandom_range(0, 9))
				0: hi = lo;
				1: ;
				default: begin
					if (lo > hi) begin
						t  = lo;
						lo = hi;
						hi = t;
					end
				end
			endcase
			program_fader(fl, ce, pick_step(), pick_timer(), pick_timer(), lo, hi);

			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					send_force(pick_level());
				else
					send_tick(pick_sensor());
			end
		end
		pacing_on = 1'b1;
	endtask

	// Longest timers: neither a fade nor a sampling may happen over a run of
	// ticks; then sample on every tick while the fade delay still holds.
	task automatic test_long_timers();
		program_fader(0, 255, 255, 65535, 65535, 0, 4095);
		send_force(0);
		repeat (20) send_tick(4095);
		program_fader(0, 255, 255, 65535, 0, 0, 4095);
		repeat (3) send_tick(4095);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		// every input known from time zero, with reset asserted before release
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= aabf_pkg::CFG_LEVEL_FLOOR;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.op           <= aabf_pkg::OP_TICK;
		in_ch.light_sample <= '0;
		in_ch.forced_level <= '0;
		reset_fader_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_force_clamp();
		test_map_extremes();
		test_equal_sensor_bounds();
		test_inverted_bounds();
		test_zero_step();
		test_slow_fade();
		test_random_phases();
		test_long_timers();

		// drain, then let the longest divide pass before judging
		wait_idle();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && levels_due.size() == 0)
			$display("** ambient_auto_brightness_fader_core: PASSED **");
		else
			$display("** ambient_auto_brightness_fader_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/aabf_pkg.sv
src/aabf_if.sv
src/aabf_ctrl.sv
src/aabf_dp.sv
src/ambient_auto_brightness_fader_core.sv
test/ambient_auto_brightness_fader_core_tb.sv
